>>> design/dcsm_pkg.sv
// Shared types, constants and the segment table for the decimal counter display.
package dcsm_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int DIGIT_BITS = 4;
   localparam int COUNT_BITS = 14;
   localparam int SCAN_BITS  = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 14'd9999;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TOP = 4'd9;

   localparam logic [1:0] CSR_STEP_MS    = 2'd0;
   localparam logic [1:0] CSR_WRAP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DIGIT_MS   = 2'd2;

   localparam logic [15:0] STEP_MS_RESET    = 16'd50;
   localparam logic [13:0] WRAP_LIMIT_RESET = 14'd1999;
   localparam logic [7:0]  DIGIT_MS_RESET   = 8'd2;

   localparam logic [SCAN_BITS-1:0] UNITS_POS = 2'd0;

   typedef struct packed {
      logic carry;
      logic clear;
   } up_link_type;

   function automatic logic [7:0] seg_encode(input logic [DIGIT_BITS-1:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h3F;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5B;
         4'd3: s = 8'h4F;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6D;
         4'd6: s = 8'h7D;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7F;
         4'd9: s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

>>> design/dcsm_digit_cell.sv
// One decimal digit cell: holds a digit, passes carry up and leading-zero blanking down.
module dcsm_digit_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  dcsm_pkg::up_link_type          up_in,
   input  logic                           blank_in,
   output dcsm_pkg::up_link_type          up_out,
   output logic                           blank_out,
   output logic [dcsm_pkg::DIGIT_BITS-1:0] digit_next,
   output logic [dcsm_pkg::DIGIT_BITS-1:0] digit
);

   logic [dcsm_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [dcsm_pkg::DIGIT_BITS-1:0] digit_in;
   logic                            at_top;

   always_comb begin
      at_top = (digit_ff == dcsm_pkg::DIGIT_TOP);
      if (up_in.clear) begin
         digit_in = '0;
      end else if (up_in.carry) begin
         digit_in = at_top ? '0 : digit_ff + 4'd1;
      end else begin
         digit_in = digit_ff;
      end
      up_out.carry = up_in.carry && at_top;
      up_out.clear = up_in.clear;
      blank_out    = blank_in && (digit_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit_next = digit_in;
   assign digit      = digit_ff;

endmodule

>>> design/decimal_counter_sevenseg_mux_top.sv
// Top level of the multiplexed four-digit decimal counter with seven-segment scan.
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while the output register is empty or being drained.
// The output register takes a new item whenever it is empty or being drained.
// Reset clears the count, both timers, the scan pointer and the output valid flag,
// and loads the configuration registers with their defaults; no clearing pass.
module decimal_counter_sevenseg_mux_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] tick, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] segments, [11:8] digit_enable_n, [25:12] count_value
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int ND = dcsm_pkg::NUM_DIGITS;
   localparam int DB = dcsm_pkg::DIGIT_BITS;
   localparam int CB = dcsm_pkg::COUNT_BITS;
   localparam int SB = dcsm_pkg::SCAN_BITS;

   logic [15:0]   step_ms_ff;
   logic [13:0]   wrap_limit_ff;
   logic [7:0]    digit_ms_ff;

   logic [CB-1:0] count_ff, count_in;
   logic [15:0]   step_timer_ff, step_timer_in;
   logic [7:0]    dwell_ff, dwell_in;
   logic [SB-1:0] scan_ff, scan_in;

   logic          rsp_valid_ff;
   logic [7:0]    seg_ff;
   logic [3:0]    den_ff;
   logic [CB-1:0] cnt_ff;

   logic          accept;
   logic          tick_act;
   logic [16:0]   elapsed;
   logic [8:0]    dwell_sum;
   logic          advance;
   logic [CB-1:0] limit;
   logic          wrap;
   logic          blank_sel;
   logic [7:0]    seg_next;

   dcsm_pkg::up_link_type up_chain [ND+1];
   logic                  blank_chain [ND+1];
   logic [DB-1:0]         digit_next [ND];
   logic [DB-1:0]         digit_now [ND];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign tick_act   = accept && req_tdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ms_ff    <= dcsm_pkg::STEP_MS_RESET;
         wrap_limit_ff <= dcsm_pkg::WRAP_LIMIT_RESET;
         digit_ms_ff   <= dcsm_pkg::DIGIT_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dcsm_pkg::CSR_STEP_MS:    step_ms_ff    <= csr_wdata;
            dcsm_pkg::CSR_WRAP_LIMIT: wrap_limit_ff <= csr_wdata[13:0];
            dcsm_pkg::CSR_DIGIT_MS:   digit_ms_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      elapsed   = {1'b0, step_timer_ff} + 17'd1;
      advance   = tick_act && (elapsed > {1'b0, step_ms_ff});
      limit     = (wrap_limit_ff > dcsm_pkg::COUNT_MAX) ? dcsm_pkg::COUNT_MAX : wrap_limit_ff;
      wrap      = (count_ff >= limit);
      count_in  = count_ff;
      step_timer_in = step_timer_ff;
      if (advance) begin
         count_in      = wrap ? '0 : count_ff + 14'd1;
         step_timer_in = '0;
      end else if (tick_act) begin
         step_timer_in = elapsed[15:0];
      end

      dwell_sum = {1'b0, dwell_ff} + 9'd1;
      dwell_in  = dwell_ff;
      scan_in   = scan_ff;
      if (tick_act) begin
         if (dwell_sum >= {1'b0, digit_ms_ff}) begin
            dwell_in = '0;
            scan_in  = scan_ff + 2'd1;
         end else begin
            dwell_in = dwell_sum[7:0];
         end
      end
   end

   assign up_chain[0]     = {advance && !wrap, advance && wrap};
   assign blank_chain[ND] = 1'b1;

   always_comb begin
      blank_sel = blank_chain[{1'b0, scan_ff}] && (scan_ff != dcsm_pkg::UNITS_POS);
      seg_next  = blank_sel ? 8'h00 : dcsm_pkg::seg_encode(digit_next[scan_ff]);
   end

   for (genvar k = 0; k < ND; k++) begin : g_cell
      dcsm_digit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_in      (up_chain[k]),
         .blank_in   (blank_chain[k+1]),
         .up_out     (up_chain[k+1]),
         .blank_out  (blank_chain[k]),
         .digit_next (digit_next[k]),
         .digit      (digit_now[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         step_timer_ff <= '0;
         dwell_ff      <= '0;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         step_timer_ff <= step_timer_in;
         dwell_ff      <= dwell_in;
         scan_ff       <= scan_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_ff <= seg_next;
         den_ff <= ~(4'b0001 << scan_ff);
         cnt_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, cnt_ff, den_ff, seg_ff};

   // The binary count and the digit cells must always agree.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == (CB'(digit_now[3]) * 14'd1000 + CB'(digit_now[2]) * 14'd100
                   + CB'(digit_now[1]) * 14'd10 + CB'(digit_now[0])))
      else $error("binary count and digit cells disagree");

   // The count wraps before the thousands digit can carry out.
   assert property (@(posedge clock) disable iff (reset) !up_chain[ND].carry)
      else $error("carry out of the thousands digit");

   // Without an accepted item the counter state holds.
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(count_ff) && $stable(scan_ff) && $stable(step_timer_ff)))
      else $error("counter state changed without an item");

   // A result always enables exactly one digit and leaves bit 7 clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($onehot(~den_ff) && !seg_ff[7]))
      else $error("bad digit enable or segment byte");

endmodule
